/* rtl/core/wmid_pkg.sv */
// shared types and constants of the windowed motion interval detector
package wmid_pkg;

   // field widths
   localparam int TAG_W  = 16;
   localparam int TIME_W = 32;
   localparam int POS_W  = 24;
   localparam int THR_W  = 24;
   localparam int SQ_W   = 2 * POS_W;
   localparam int SUM_W  = SQ_W + 2;

   // port widths
   localparam int REQ_TDATA_W = 120;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_TUSER_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // request tdata layout, lowest bit first
   localparam int REQ_TAG_LSB  = 0;
   localparam int REQ_TIME_LSB = REQ_TAG_LSB + TAG_W;
   localparam int REQ_X_LSB    = REQ_TIME_LSB + TIME_W;
   localparam int REQ_Y_LSB    = REQ_X_LSB + POS_W;
   localparam int REQ_Z_LSB    = REQ_Y_LSB + POS_W;

   // request kinds carried in tuser
   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_CLEAR  = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OBJECT_SELECT      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SPAN        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_THRESHOLD = 2'd2;

   localparam logic [TIME_W-1:0] WINDOW_SPAN_RESET = 32'd1000000;

   // controller to datapath
   typedef struct packed {
      logic load;        // latch a matching sample beat
      logic clear;       // empty the window
      logic insert;      // write the sample into the ring
      logic ev_read;     // read the oldest time
      logic evict;       // drop the oldest sample
      logic keep_start;  // hold the oldest time as interval start
      logic scan_init;   // set up the distance scan
      logic scan_issue;  // read one older sample
      logic emit;        // load the result register
   } wmid_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_clear;
      logic tag_match;
      logic evict_cond;
      logic count_gt1;
      logic scan_last;
      logic pipe_busy;
      logic hit;
      logic out_free;
   } wmid_sts_type;

   // square of a magnitude
   function automatic logic [SQ_W-1:0] sq_mag(input logic [POS_W-1:0] a);
      return SQ_W'(a) * SQ_W'(a);
   endfunction

   // absolute difference of two signed positions
   function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
      logic signed [POS_W:0] d;
      logic [POS_W:0] m;
      d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
      m = d[POS_W] ? (POS_W+1)'(-d) : (POS_W+1)'(d);
      return m[POS_W-1:0];
   endfunction

endpackage

/* rtl/core/wmid_ctrl.sv */
// sequencing state machine of the motion interval detector
module wmid_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  wmid_pkg::wmid_sts_type sts,
   output wmid_pkg::wmid_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INSERT = 3'd1;
   localparam logic [2:0] ST_EV_RD  = 3'd2;
   localparam logic [2:0] ST_EV_CMP = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;
   localparam logic [2:0] ST_DECIDE = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (sts.is_clear) begin
                  cmd.clear = 1'b1;
               end else if (sts.tag_match) begin
                  cmd.load = 1'b1;
                  state_in = ST_INSERT;
               end
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_EV_RD;
         end
         ST_EV_RD: begin
            cmd.ev_read = 1'b1;
            state_in    = ST_EV_CMP;
         end
         ST_EV_CMP: begin
            if (sts.evict_cond) begin
               cmd.evict = 1'b1;
               state_in  = ST_EV_RD;
            end else begin
               cmd.keep_start = 1'b1;
               if (sts.count_gt1) begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!sts.hit) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/wmid_dp.sv */
// sample ring, distance scan pipeline and interval tracking
module wmid_dp #(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [wmid_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wmid_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [wmid_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [wmid_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [wmid_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [wmid_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   input  wmid_pkg::wmid_cmd_type               cmd,
   output wmid_pkg::wmid_sts_type               sts
);

   localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);
   localparam logic [CNT_W-1:0] CNT_TOP  = CNT_W'(WINDOW_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_W1 = (PTR_W+1)'(WINDOW_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

   localparam int TAG_W  = wmid_pkg::TAG_W;
   localparam int TIME_W = wmid_pkg::TIME_W;
   localparam int POS_W  = wmid_pkg::POS_W;
   localparam int THR_W  = wmid_pkg::THR_W;
   localparam int SQ_W   = wmid_pkg::SQ_W;
   localparam int SUM_W  = wmid_pkg::SUM_W;

   // ring pointer step with wrap
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   // ring pointer sum with wrap, both operands below the depth
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
      logic [PTR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_W1) begin
         s = s - DEPTH_W1;
      end
      return s[PTR_W-1:0];
   endfunction

   // configuration registers
   logic [TAG_W-1:0]  object_select_ff;
   logic [TIME_W-1:0] window_span_ff;
   logic [THR_W-1:0]  distance_threshold_ff;

   // latched sample
   logic [TIME_W-1:0] time_ff;
   logic [POS_W-1:0]  x_ff, y_ff, z_ff;
   logic [SQ_W-1:0]   thr2_ff;

   // window bookkeeping
   logic [PTR_W-1:0]  oldest_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              overflow_ff;
   logic [TIME_W-1:0] rd_time_ff;
   logic [TIME_W-1:0] start_ff;

   // scan pipeline
   logic [PTR_W-1:0]  scan_ptr_ff;
   logic [CNT_W-1:0]  remain_ff;
   logic              p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic [POS_W-1:0]  rd_x_ff, rd_y_ff, rd_z_ff;
   logic [SQ_W-1:0]   sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  best_ff;

   // interval tracking
   logic              have_ff;
   logic [TIME_W-1:0] last_start_ff, last_end_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [wmid_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic [wmid_pkg::RSP_TUSER_W-1:0] rsp_user_ff;

   // sample ring
   logic [TIME_W-1:0] times_mem [WINDOW_DEPTH];
   logic [POS_W-1:0]  xs_mem    [WINDOW_DEPTH];
   logic [POS_W-1:0]  ys_mem    [WINDOW_DEPTH];
   logic [POS_W-1:0]  zs_mem    [WINDOW_DEPTH];

   // insertion slot, with the oldest dropped when full
   logic             full;
   logic [PTR_W-1:0] oldest_ins;
   logic [CNT_W-1:0] count_ins;
   logic [PTR_W-1:0] wr_slot;
   logic             extend_last;

   assign full        = (count_ff == CNT_FULL);
   assign oldest_ins  = full ? ptr_inc(oldest_ff) : oldest_ff;
   assign count_ins   = full ? CNT_TOP : count_ff;
   assign wr_slot     = ptr_add(oldest_ins, count_ins[PTR_W-1:0]);
   assign extend_last = have_ff && (last_end_ff >= start_ff);

   // status towards the controller
   always_comb begin
      sts            = '0;
      sts.is_clear   = (req_tuser[0] == wmid_pkg::ACTION_CLEAR);
      sts.tag_match  = (req_tdata[wmid_pkg::REQ_TAG_LSB +: TAG_W] == object_select_ff);
      sts.count_gt1  = (count_ff > CNT_W'(1));
      sts.evict_cond = sts.count_gt1 && (time_ff >= rd_time_ff)
                       && ((time_ff - rd_time_ff) > window_span_ff);
      sts.scan_last  = (remain_ff == CNT_W'(1));
      sts.pipe_busy  = p1_valid_ff || p2_valid_ff || p3_valid_ff;
      sts.hit        = (distance_threshold_ff != '0) && sts.count_gt1
                       && (best_ff >= SUM_W'(thr2_ff));
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         object_select_ff      <= '0;
         window_span_ff        <= wmid_pkg::WINDOW_SPAN_RESET;
         distance_threshold_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            wmid_pkg::CSR_OBJECT_SELECT:      object_select_ff <= csr_wdata[TAG_W-1:0];
            wmid_pkg::CSR_WINDOW_SPAN:        window_span_ff   <= csr_wdata[TIME_W-1:0];
            wmid_pkg::CSR_DISTANCE_THRESHOLD: distance_threshold_ff <= csr_wdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sample latch and threshold square
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         time_ff <= req_tdata[wmid_pkg::REQ_TIME_LSB +: TIME_W];
         x_ff    <= req_tdata[wmid_pkg::REQ_X_LSB +: POS_W];
         y_ff    <= req_tdata[wmid_pkg::REQ_Y_LSB +: POS_W];
         z_ff    <= req_tdata[wmid_pkg::REQ_Z_LSB +: POS_W];
         thr2_ff <= SQ_W'(distance_threshold_ff) * SQ_W'(distance_threshold_ff);
      end
   end

   // ring write and reads
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         times_mem[wr_slot] <= time_ff;
         xs_mem[wr_slot]    <= x_ff;
         ys_mem[wr_slot]    <= y_ff;
         zs_mem[wr_slot]    <= z_ff;
      end
      if (cmd.ev_read) begin
         rd_time_ff <= times_mem[oldest_ff];
      end
      if (cmd.scan_issue) begin
         rd_x_ff <= xs_mem[scan_ptr_ff];
         rd_y_ff <= ys_mem[scan_ptr_ff];
         rd_z_ff <= zs_mem[scan_ptr_ff];
      end
   end

   // occupancy and oldest pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         count_ff  <= '0;
      end else if (cmd.clear) begin
         oldest_ff <= '0;
         count_ff  <= '0;
      end else if (cmd.insert) begin
         oldest_ff <= oldest_ins;
         count_ff  <= count_ins + 1'b1;
      end else if (cmd.evict) begin
         oldest_ff <= ptr_inc(oldest_ff);
         count_ff  <= count_ff - 1'b1;
      end
   end

   // overflow flag and interval start
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         overflow_ff <= full;
      end
      if (cmd.keep_start) begin
         start_ff <= rd_time_ff;
      end
   end

   // scan address stepping
   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else if (cmd.scan_init) begin
         remain_ff <= count_ff - 1'b1;
      end else if (cmd.scan_issue) begin
         remain_ff <= remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_ptr_ff <= oldest_ff;
      end else if (cmd.scan_issue) begin
         scan_ptr_ff <= ptr_inc(scan_ptr_ff);
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.scan_issue;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   // per-axis squares, sum, running maximum
   always_ff @(posedge clock) begin
      if (p1_valid_ff) begin
         sq_x_ff <= wmid_pkg::sq_mag(wmid_pkg::abs_diff(rd_x_ff, x_ff));
         sq_y_ff <= wmid_pkg::sq_mag(wmid_pkg::abs_diff(rd_y_ff, y_ff));
         sq_z_ff <= wmid_pkg::sq_mag(wmid_pkg::abs_diff(rd_z_ff, z_ff));
      end
      if (p2_valid_ff) begin
         sum_ff <= SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
      end
      if (cmd.scan_init) begin
         best_ff <= '0;
      end else if (p3_valid_ff && (sum_ff > best_ff)) begin
         best_ff <= sum_ff;
      end
   end

   // interval tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff       <= 1'b0;
         last_start_ff <= '0;
         last_end_ff   <= '0;
      end else if (cmd.emit) begin
         have_ff     <= 1'b1;
         last_end_ff <= time_ff;
         if (!extend_last) begin
            last_start_ff <= start_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {time_ff, extend_last ? last_start_ff : start_ff};
         rsp_user_ff <= {overflow_ff, extend_last};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* rtl/core/windowed_motion_interval_detector.sv */
// top level of the windowed motion interval detector
// Samples of the selected object enter a ring of WINDOW_DEPTH entries; the
// block drops samples older than window_span, then compares the squared
// distance from the newest sample to every older one against the squared
// threshold and reports the window's time interval, merged with the last one
// where they touch. Work is one sample at a time: no new beat is taken
// until the last sample is through. Each eviction step reads the oldest time
// on the time ring's read port and then compares it, and the distance scan
// reads one older sample per cycle through a three-stage square and maximum
// pipeline, drained before the decision. Clear beats and samples of other
// objects are taken in the idle state, which they do not leave. A finished
// result waits in an output register while the next beat is taken; a second
// result stalls until the first has gone.
module windowed_motion_interval_detector #(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // object_tag, time_us, pos_x, pos_y, pos_z
   input  logic [wmid_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action
   input  logic [wmid_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // interval_start, interval_end
   output logic [wmid_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // extends_previous, window_overflow
   output logic [wmid_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input  logic                               csr_we,
   input  logic [wmid_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wmid_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   wmid_pkg::wmid_cmd_type cmd;
   wmid_pkg::wmid_sts_type sts;

   // sequencer
   wmid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath
   wmid_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

/* rtl/core/wmid_checker.sv */
// port-level checks of the motion interval detector and their binding
module wmid_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [wmid_pkg::REQ_TUSER_W-1:0] req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [wmid_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [wmid_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   // a stalled result holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // no result is pending right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // a result is never produced in the cycle after a beat is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared one cycle after a request beat");

   // straight after a sample beat is taken, no new result is raised while ready
   a_ready_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == wmid_pkg::ACTION_SAMPLE)
      && !$past(reset) |=> !(rsp_tvalid && !$past(rsp_tvalid) && req_tready))
      else $error("result raised while the block took a new beat");

endmodule

bind windowed_motion_interval_detector wmid_checker u_wmid_checker (.*);
